@@ rtl/core/tmbp_pkg.sv @@
// ----------------------------------------------------------------------------
// tmbp_pkg
// Shared types, codes and record builders for the tracker module byte parser.
// ----------------------------------------------------------------------------
package tmbp_pkg;

    typedef enum logic [2:0] {
        PH_SONG,
        PH_COUNT,
        PH_ORDER,
        PH_PLEN,
        PH_CHECK,
        PH_NOTE2,
        PH_NOTE4,
        PH_DONE
    } phase_t;

    localparam logic [2:0] REC_SONG_LEN   = 3'd0;
    localparam logic [2:0] REC_PAT_COUNT  = 3'd1;
    localparam logic [2:0] REC_ORDER      = 3'd2;
    localparam logic [2:0] REC_PAT_START  = 3'd3;
    localparam logic [2:0] REC_ROW        = 3'd4;

    localparam logic [7:0] CHK_CH1        = 8'h80;
    localparam logic [7:0] CHK_CH2        = 8'h40;
    localparam logic [7:0] CHK_CH3        = 8'h20;
    localparam logic [7:0] CHK_CH4        = 8'h10;
    localparam logic [7:0] CHK_CH2_C4     = 8'h08;
    localparam logic [7:0] CHK_CH2_OFF    = 8'h04;
    localparam logic [7:0] CHK_CH1_F6     = 8'h02;
    localparam logic [7:0] CHK_CH3_F6     = 8'h01;
    localparam logic [7:0] NIBBLE_MASK    = 8'h0f;

    localparam logic [7:0] NOTE_F6        = 8'd78;
    localparam logic [7:0] NOTE_C4        = 8'd49;
    localparam logic [7:0] NOTE_OFF       = 8'd99;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [2:0] record_type;
        logic [7:0] value_a;
        logic [7:0] value_b;
        logic       ch1_active;
        logic [7:0] ch1_note;
        logic       ch2_active;
        logic [7:0] ch2_note;
        logic       ch3_active;
        logic [7:0] ch3_note;
        logic       ch4_active;
        logic [7:0] ch4_note;
        logic       last;
    } rec_t;

    typedef struct packed {
        logic [1:0] count;
        rec_t       rec0;
        rec_t       rec1;
    } push_t;

    function automatic rec_t make_simple(logic [2:0] rtype, logic [7:0] a, logic [7:0] b);
        rec_t r;
        r             = '0;
        r.record_type = rtype;
        r.value_a     = a;
        r.value_b     = b;
        return r;
    endfunction

    function automatic rec_t make_row(logic [7:0] check, logic [7:0] ch2_byte, logic ch2_read,
                                      logic ch4_read, logic [7:0] ch4_byte, logic trunc,
                                      logic [7:0] pidx);
        rec_t r;
        r = make_simple(REC_ROW, pidx, {7'd0, trunc});
        if ((check & CHK_CH1) != 8'd0)
        begin
            r.ch1_active = 1'b1;
            r.ch1_note   = ((check & CHK_CH1_F6) != 8'd0) ? NOTE_F6 : NOTE_OFF;
        end
        if ((check & CHK_CH2) != 8'd0)
        begin
            if ((check & CHK_CH2_OFF) != 8'd0)
            begin
                r.ch2_active = 1'b1;
                r.ch2_note   = NOTE_OFF;
            end
            else if ((check & CHK_CH2_C4) != 8'd0)
            begin
                r.ch2_active = 1'b1;
                r.ch2_note   = NOTE_C4;
            end
            else if (ch2_read)
            begin
                r.ch2_active = 1'b1;
                r.ch2_note   = ch2_byte;
            end
        end
        if ((check & CHK_CH3) != 8'd0)
        begin
            r.ch3_active = 1'b1;
            r.ch3_note   = ((check & CHK_CH3_F6) != 8'd0) ? NOTE_F6 : NOTE_OFF;
        end
        if (((check & CHK_CH4) != 8'd0) && ch4_read)
        begin
            r.ch4_active = 1'b1;
            r.ch4_note   = ch4_byte;
        end
        return r;
    endfunction

endpackage

@@ rtl/core/tmbp_parse.sv @@
// ----------------------------------------------------------------------------
// tmbp_parse
// Input word register, parse state and single-pass decode into up to two
// records per byte.
// ----------------------------------------------------------------------------
module tmbp_parse
    import tmbp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            data_byte,
    input  logic                  start_of_module,
    input  logic [FIFO_CNT_W-1:0] space,
    output push_t                 push
);

    logic       vld_reg;
    logic [7:0] byte_reg;
    logic       som_reg;

    phase_t     phase_reg,        phase_next;
    logic [7:0] song_len_reg,     song_len_next;
    logic [7:0] order_index_reg,  order_index_next;
    logic [7:0] pattern_total_reg, pattern_total_next;
    logic [7:0] pattern_index_reg, pattern_index_next;
    logic [7:0] bytes_left_reg,   bytes_left_next;
    logic [7:0] held_check_reg,   held_check_next;
    logic [7:0] held_ch2_reg,     held_ch2_next;
    logic [1:0] pending_reg,      pending_next;

    phase_t     ph;
    logic [7:0] sl, oi, pt, pi, bl, hc, h2;
    logic [1:0] np;
    logic [7:0] oi_inc, oi_inc2, pi_inc, bl_dec;
    logic       need2;
    logic [1:0] chk_np;
    logic       row_end;
    logic [1:0] n;
    rec_t       rec0, rec1;
    logic       consume;

    // restart mark takes the byte against reset state
    always_comb
    begin
        ph = som_reg ? PH_SONG : phase_reg;
        sl = som_reg ? 8'd0 : song_len_reg;
        oi = som_reg ? 8'd0 : order_index_reg;
        pt = som_reg ? 8'd0 : pattern_total_reg;
        pi = som_reg ? 8'd0 : pattern_index_reg;
        bl = som_reg ? 8'd0 : bytes_left_reg;
        hc = som_reg ? 8'd0 : held_check_reg;
        h2 = som_reg ? 8'd0 : held_ch2_reg;
        np = som_reg ? 2'd0 : pending_reg;
    end

    assign oi_inc  = oi + 8'd1;
    assign oi_inc2 = oi + 8'd2;
    assign pi_inc  = pi + 8'd1;
    assign bl_dec  = bl - 8'd1;
    assign need2   = ((byte_reg & CHK_CH2) != 8'd0) && ((byte_reg & CHK_CH2_OFF) == 8'd0)
                     && ((byte_reg & CHK_CH2_C4) == 8'd0);
    assign chk_np  = {1'b0, need2} + {1'b0, ((byte_reg & CHK_CH4) != 8'd0)};

    always_comb
    begin
        phase_next         = ph;
        song_len_next      = sl;
        order_index_next   = oi;
        pattern_total_next = pt;
        pattern_index_next = pi;
        bytes_left_next    = bl;
        held_check_next    = hc;
        held_ch2_next      = h2;
        pending_next       = np;
        rec0               = '0;
        rec1               = '0;
        n                  = 2'd0;
        row_end            = 1'b0;
        case (ph)
            PH_SONG:
            begin
                song_len_next = byte_reg;
                rec0          = make_simple(REC_SONG_LEN, byte_reg, 8'd0);
                n             = 2'd1;
                phase_next    = PH_COUNT;
            end
            PH_COUNT:
            begin
                pattern_total_next = byte_reg;
                rec0               = make_simple(REC_PAT_COUNT, byte_reg, 8'd0);
                n                  = 2'd1;
                if (sl != 8'd0)
                    phase_next = PH_ORDER;
                else
                    phase_next = (byte_reg == 8'd0) ? PH_DONE : PH_PLEN;
            end
            PH_ORDER:
            begin
                rec0             = make_simple(REC_ORDER, {4'd0, byte_reg[7:4]}, 8'd0);
                n                = 2'd1;
                order_index_next = oi_inc;
                if (oi_inc < sl)
                begin
                    rec1             = make_simple(REC_ORDER, byte_reg & NIBBLE_MASK, 8'd0);
                    n                = 2'd2;
                    order_index_next = oi_inc2;
                end
                if (order_index_next >= sl)
                    phase_next = (pt == 8'd0) ? PH_DONE : PH_PLEN;
            end
            PH_PLEN:
            begin
                rec0            = make_simple(REC_PAT_START, pi, byte_reg);
                n               = 2'd1;
                bytes_left_next = byte_reg;
                if (byte_reg == 8'd0)
                    row_end = 1'b1;
                else
                    phase_next = PH_CHECK;
            end
            PH_CHECK:
            begin
                held_check_next = byte_reg;
                held_ch2_next   = 8'd0;
                bytes_left_next = bl_dec;
                pending_next    = chk_np;
                if (chk_np == 2'd0)
                begin
                    rec0    = make_row(byte_reg, 8'd0, 1'b0, 1'b0, 8'd0, 1'b0, pi);
                    n       = 2'd1;
                    row_end = 1'b1;
                end
                else if (bl_dec == 8'd0)
                begin
                    rec0         = make_row(byte_reg, 8'd0, 1'b0, 1'b0, 8'd0, 1'b1, pi);
                    n            = 2'd1;
                    pending_next = 2'd0;
                    row_end      = 1'b1;
                end
                else
                begin
                    phase_next = need2 ? PH_NOTE2 : PH_NOTE4;
                end
            end
            PH_NOTE2:
            begin
                held_ch2_next   = byte_reg;
                bytes_left_next = bl_dec;
                pending_next    = np - 2'd1;
                if (pending_next == 2'd0)
                begin
                    rec0    = make_row(hc, byte_reg, 1'b1, 1'b0, 8'd0, 1'b0, pi);
                    n       = 2'd1;
                    row_end = 1'b1;
                end
                else if (bl_dec == 8'd0)
                begin
                    rec0         = make_row(hc, byte_reg, 1'b1, 1'b0, 8'd0, 1'b1, pi);
                    n            = 2'd1;
                    pending_next = 2'd0;
                    row_end      = 1'b1;
                end
                else
                begin
                    phase_next = PH_NOTE4;
                end
            end
            PH_NOTE4:
            begin
                bytes_left_next = bl_dec;
                pending_next    = 2'd0;
                rec0            = make_row(hc, h2, 1'b1, 1'b1, byte_reg, 1'b0, pi);
                n               = 2'd1;
                row_end         = 1'b1;
            end
            default:
            begin
                n = 2'd0;
            end
        endcase

        if (row_end)
        begin
            if (bytes_left_next == 8'd0)
            begin
                pattern_index_next = pi_inc;
                phase_next         = (pi_inc == pt) ? PH_DONE : PH_PLEN;
            end
            else
            begin
                phase_next = PH_CHECK;
            end
        end

        if (n == 2'd2)
            rec1.last = 1'b1;
        else if (n == 2'd1)
            rec0.last = 1'b1;
    end

    assign consume    = vld_reg && ({{(FIFO_CNT_W-2){1'b0}}, n} <= space);
    assign in_stall   = vld_reg && !consume;
    assign push.count = consume ? n : 2'd0;
    assign push.rec0  = rec0;
    assign push.rec1  = rec1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= data_byte;
            som_reg  <= start_of_module;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_SONG;
            song_len_reg      <= 8'd0;
            order_index_reg   <= 8'd0;
            pattern_total_reg <= 8'd0;
            pattern_index_reg <= 8'd0;
            bytes_left_reg    <= 8'd0;
            held_check_reg    <= 8'd0;
            held_ch2_reg      <= 8'd0;
            pending_reg       <= 2'd0;
        end
        else if (consume)
        begin
            phase_reg         <= phase_next;
            song_len_reg      <= song_len_next;
            order_index_reg   <= order_index_next;
            pattern_total_reg <= pattern_total_next;
            pattern_index_reg <= pattern_index_next;
            bytes_left_reg    <= bytes_left_next;
            held_check_reg    <= held_check_next;
            held_ch2_reg      <= held_ch2_next;
            pending_reg       <= pending_next;
        end
    end

endmodule

@@ rtl/core/tmbp_out_fifo.sv @@
// ----------------------------------------------------------------------------
// tmbp_out_fifo
// Register queue: takes up to two records a cycle, gives one unless stalled.
// ----------------------------------------------------------------------------
module tmbp_out_fifo
    import tmbp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  push_t                 push,
    output logic [FIFO_CNT_W-1:0] space,
    output logic                  out_valid,
    input  logic                  out_stall,
    output rec_t                  head
);

    rec_t                  mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg,  count_next;
    logic                  pop;
    logic [FIFO_PTR_W-1:0] wr_ptr_inc;

    localparam logic [FIFO_CNT_W-1:0] DEPTH_CNT = FIFO_CNT_W'(FIFO_DEPTH);

    assign space       = DEPTH_CNT - count_reg;
    assign out_valid   = (count_reg != '0);
    assign pop         = out_valid && !out_stall;
    assign head        = mem[rd_ptr_reg];
    assign wr_ptr_inc  = wr_ptr_reg + FIFO_PTR_W'(1);
    assign wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push.count);
    assign rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
    assign count_next  = count_reg + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[wr_ptr_reg] <= push.rec0;
        if (push.count == 2'd2)
            mem[wr_ptr_inc] <= push.rec1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/core/tracker_module_byte_parser.sv @@
// ----------------------------------------------------------------------------
// tracker_module_byte_parser
// Streaming parser for a compact four-channel tracker module image.
// ----------------------------------------------------------------------------
// One input word per cycle is taken into an input register while in_stall is
// low, decoded in a single pass against the parse state and written as up to
// two records into a four-entry output queue whose head drives the output.
// The block sustains one word per cycle while the output side takes one
// record per cycle; an order byte holding two entries puts two records in
// the queue, so under continuous traffic the input stalls once the queue
// fills. start_of_module restarts the parse at any point, and after the last
// pattern further words are consumed silently.
module tracker_module_byte_parser
    import tmbp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       start_of_module,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] record_type,
    output logic [7:0] value_a,
    output logic [7:0] value_b,
    output logic       ch1_active,
    output logic [7:0] ch1_note,
    output logic       ch2_active,
    output logic [7:0] ch2_note,
    output logic       ch3_active,
    output logic [7:0] ch3_note,
    output logic       ch4_active,
    output logic [7:0] ch4_note,
    output logic       last
);

    push_t                 push;
    logic [FIFO_CNT_W-1:0] space;
    rec_t                  head;

    tmbp_parse u_parse (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .data_byte       (data_byte),
        .start_of_module (start_of_module),
        .space           (space),
        .push            (push)
    );

    tmbp_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space     (space),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign record_type = head.record_type;
    assign value_a     = head.value_a;
    assign value_b     = head.value_b;
    assign ch1_active  = head.ch1_active;
    assign ch1_note    = head.ch1_note;
    assign ch2_active  = head.ch2_active;
    assign ch2_note    = head.ch2_note;
    assign ch3_active  = head.ch3_active;
    assign ch3_note    = head.ch3_note;
    assign ch4_active  = head.ch4_active;
    assign ch4_note    = head.ch4_note;
    assign last        = head.last;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> ({{(FIFO_CNT_W-2){1'b0}}, push.count} <= space))
        else $error("output queue overflow");

    a_stall_needs_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output queue");

    a_single_records_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (record_type != REC_ORDER)) |-> last)
        else $error("non-order record without last");

    a_pair_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == 2'd2) |-> (!push.rec0.last && push.rec1.last))
        else $error("record pair marked wrongly");

endmodule
